/* rtl/core/sbeq_pkg.sv */
// shared constants, types and fixed-point helpers for the stereo biquad eq core
// no dependencies; used by the interfaces, imported by the top level, the knee divider and the test files
`timescale 1ns / 1ps

package sbeq_pkg;

    // fixed formats of the item fields
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int COEF_W         = 32;
    localparam int GAIN_W         = 24;
    localparam int GAIN_FRAC      = 20;
    localparam int SEC_IDX_W      = 4;
    localparam int COEF_IDX_W     = 3;
    localparam int SEC_EN_W       = 12;
    localparam int BAND_CNT_W     = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam int PEAK_BANDS_DEF = 10;
    localparam int COEFS_PER_SEC  = 5;

    // internal formats
    localparam int SIG_FRAC  = SAMPLE_BITS - 1;
    localparam int SIG_W     = SAMPLE_BITS + 8;
    localparam int DLY_W     = 48;
    localparam int DLY_FRAC  = 32;
    localparam int MUL_W     = ((SIG_W > COEF_W) ? SIG_W : COEF_W) + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int COEF_SH   = SIG_FRAC + COEF_FRAC_BITS - DLY_FRAC;
    localparam int Y_SH      = DLY_FRAC - SIG_FRAC;
    localparam int MAG_W     = DLY_W - 1;
    localparam int DEN_W     = MAG_W + 5;
    localparam int QW        = SIG_FRAC;
    localparam int OUT_EXT_W = SAMPLE_BITS + 2;

    localparam longint KNEE_T_I = ((64'd89 << SIG_FRAC) + 64'd50) / 64'd100;
    localparam logic [SIG_FRAC-1:0] KNEE_T = SIG_FRAC'(KNEE_T_I);

    localparam logic [DLY_W-1:0]        PROD_LIM = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic signed [DLY_W-1:0] DLY_MAX  = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic signed [DLY_W-1:0] DLY_MIN  = {1'b1, {(DLY_W-1){1'b0}}};
    localparam logic signed [SIG_W-1:0] SIG_MAX  = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN  = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // request kinds
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_COEF  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EQ_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEC,
        ST_GAIN,
        ST_KNEE
    } t_state;

    // product magnitude rounded half away from zero, clipped to +-(2^47-1)
    function automatic logic signed [DLY_W-1:0] rnd_prod(
        input logic signed [PROD_W-1:0] p,
        input int                       sh
    );
        logic [PROD_W-1:0] pa;
        logic [PROD_W:0]   q;
        logic [DLY_W-1:0]  m;
        pa = p[PROD_W-1] ? (~p + PROD_W'(1)) : p;
        q  = ({1'b0, pa} + ((PROD_W+1)'(1) << (sh - 1))) >> sh;
        if (q > (PROD_W+1)'(PROD_LIM)) begin
            m = PROD_LIM;
        end else begin
            m = q[DLY_W-1:0];
        end
        return p[PROD_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [DLY_W+1:0] v);
        logic signed [DLY_W-1:0] r;
        if (v > (DLY_W+2)'(DLY_MAX)) begin
            r = DLY_MAX;
        end else if (v < (DLY_W+2)'(DLY_MIN)) begin
            r = DLY_MIN;
        end else begin
            r = v[DLY_W-1:0];
        end
        return r;
    endfunction

    // accumulator to signal format, ties away from zero, then clipped
    function automatic logic signed [SIG_W-1:0] y_round(input logic signed [DLY_W:0] a);
        logic [DLY_W:0]          aa;
        logic [DLY_W:0]          q;
        logic signed [DLY_W+1:0] v;
        logic signed [SIG_W-1:0] r;
        aa = a[DLY_W] ? (~a + (DLY_W+1)'(1)) : a;
        q  = (aa + ((DLY_W+1)'(1) << (Y_SH - 1))) >> Y_SH;
        v  = a[DLY_W] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > (DLY_W+2)'(SIG_MAX)) begin
            r = SIG_MAX;
        end else if (v < (DLY_W+2)'(SIG_MIN)) begin
            r = SIG_MIN;
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
        input logic signed [OUT_EXT_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > OUT_EXT_W'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (v < OUT_EXT_W'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/sbeq_ifs.sv */
// valid/ready channel interfaces: request items, result items, register writes
// depends on sbeq_pkg for field widths
`timescale 1ns / 1ps

interface sbeq_req_if;
    logic                                          valid;
    logic                                          ready;
    logic                                          req_type;
    logic signed [sbeq_pkg::SAMPLE_BITS-1:0]       left_sample;
    logic signed [sbeq_pkg::SAMPLE_BITS-1:0]       right_sample;
    logic                                          last_of_buffer;
    logic [sbeq_pkg::SEC_IDX_W-1:0]                section_index;
    logic [sbeq_pkg::COEF_IDX_W-1:0]               coef_index;
    logic signed [sbeq_pkg::COEF_W-1:0]            coef_value;

    modport source (output valid, req_type, left_sample, right_sample, last_of_buffer,
                    section_index, coef_index, coef_value, input ready);
    modport sink   (input valid, req_type, left_sample, right_sample, last_of_buffer,
                    section_index, coef_index, coef_value, output ready);
endinterface

interface sbeq_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [sbeq_pkg::SAMPLE_BITS-1:0] left_out;
    logic signed [sbeq_pkg::SAMPLE_BITS-1:0] right_out;
    logic                                    last_out;

    modport source (output valid, left_out, right_out, last_out, input ready);
    modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

interface sbeq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sbeq_pkg::CFG_IDX_W-1:0]    index;
    logic [sbeq_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/stereo_biquad_eq_soft_limiter_core.sv */
// top level: stereo biquad cascade and output gain on one shared multiplier, then a soft knee per channel
// coefficients and delay rows live in two memories with registered read ports
// depends on sbeq_pkg, sbeq_ifs and sbeq_knee_div
//
//  port      | dir | transaction
//  ----------+-----+-------------------------------------------------------
//  i_frame   | in  | stereo frame or coefficient write (req_type selects)
//  o_result  | out | processed stereo frame, one per input frame
//  i_cfg     | in  | register write: index 0..4, data in low bits
//
//  a frame runs each enabled section in turn and skips each bypassed one
//  (the shared multiplier issues ten products per section), then the gain
//  phases and a knee division of SAMPLE_BITS-1 quotient bits
//  a coefficient write is taken only while idle; reset zeroes the delay state at once
//  through per-row valid bits, coefficients read back undefined until written
//  a finished frame waits in the output register while the next one is taken
`timescale 1ns / 1ps

module stereo_biquad_eq_soft_limiter_core #(
    parameter int PEAK_BANDS = sbeq_pkg::PEAK_BANDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbeq_req_if.sink     i_frame,
    sbeq_res_if.source   o_result,
    sbeq_cfg_if.sink     i_cfg
);
    import sbeq_pkg::*;

    localparam int SECTIONS  = PEAK_BANDS + 2;
    localparam int SW        = $clog2(SECTIONS);
    localparam int ZA_W      = SW + 1;
    localparam int ZDEPTH    = 2 * SECTIONS;
    localparam int CDEPTH    = COEFS_PER_SEC * SECTIONS;
    localparam int CA_W      = $clog2(CDEPTH);
    localparam int CWA_W     = SEC_IDX_W + COEF_IDX_W + 1;
    localparam int EN_PAD_W  = (SECTIONS > SEC_EN_W) ? SECTIONS : SEC_EN_W;
    localparam logic [3:0] PH_SEC_LAST  = 4'd12;
    localparam logic [3:0] PH_GAIN_LAST = 4'd4;

    // configuration registers
    logic                  r_eq;
    logic [BAND_CNT_W-1:0] r_bands;
    logic [SEC_EN_W-1:0]   r_sec_en;
    logic [GAIN_W-1:0]     r_gain [2];

    // sequencer
    t_state          r_state, n_state;
    logic [3:0]      r_ph, n_ph;
    logic [SW-1:0]   r_sec, n_sec;
    logic [CA_W-1:0] r_cbase, n_cbase;
    logic            knee_start;
    logic            out_load;
    logic            sec_last;
    logic            act;

    // datapath
    logic signed [SIG_W-1:0]  r_x   [2];
    logic signed [SIG_W-1:0]  r_y   [2];
    logic signed [DLY_W-1:0]  r_z1  [2];
    logic signed [DLY_W-1:0]  r_z2  [2];
    logic signed [DLY_W:0]    r_acc [2];
    logic signed [DLY_W:0]    r_s1  [2];
    logic signed [DLY_W-1:0]  r_s2  [2];
    logic signed [DLY_W-1:0]  r_v   [2];
    logic                     r_last;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_gain;
    logic signed [DLY_W-1:0]  r_rnd;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     ch;

    // memories
    logic signed [COEF_W-1:0]  coef_mem [CDEPTH];
    logic signed [COEF_W-1:0]  r_coef_q;
    logic                      coef_we, coef_re;
    logic [CA_W-1:0]           coef_waddr, coef_raddr;
    logic [CWA_W-1:0]          coef_wfull;

    logic [2*DLY_W-1:0]        dly_mem [ZDEPTH];
    logic [2*DLY_W-1:0]        r_zrow_q;
    logic                      r_zrow_ok;
    logic [ZDEPTH-1:0]         r_zval;
    logic                      z_we, z_re;
    logic [ZA_W-1:0]           z_waddr, z_raddr;
    logic [2*DLY_W-1:0]        z_wdata;
    logic signed [DLY_W-1:0]   z_rd1, z_rd2;

    // section enables
    logic [EN_PAD_W-1:0]       en_pad;
    logic [SECTIONS-1:0]       sec_on;

    // knee
    logic [1:0]                div_busy;
    logic [QW-1:0]             div_q   [2];
    logic [MAG_W-1:0]          mag     [2];
    logic [MAG_W-1:0]          knee_d  [2];
    logic                      knee_gt [2];
    logic signed [SAMPLE_BITS-1:0] knee_res [2];

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic                          r_out_last;

    logic frame_acc, cfg_acc, out_free;

    assign i_frame.ready = r_state == ST_IDLE;
    assign i_cfg.ready   = 1'b1;
    assign frame_acc     = i_frame.valid && i_frame.ready;
    assign cfg_acc       = i_cfg.valid && i_cfg.ready;
    assign out_free      = !r_out_valid || o_result.ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eq     <= 1'b0;
            r_bands  <= '0;
            r_sec_en <= '0;
            r_gain[0] <= GAIN_UNITY;
            r_gain[1] <= GAIN_UNITY;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_EQ_ENABLE:  r_eq      <= i_cfg.data[0];
                CFG_BAND_COUNT: r_bands   <= i_cfg.data[BAND_CNT_W-1:0];
                CFG_SEC_ENABLE: r_sec_en  <= i_cfg.data[SEC_EN_W-1:0];
                CFG_GAIN_LEFT:  r_gain[0] <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_RIGHT: r_gain[1] <= i_cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        en_pad = EN_PAD_W'(r_sec_en);
        for (int i = 0; i < SECTIONS; i++) begin
            if (i < PEAK_BANDS) begin
                sec_on[i] = en_pad[i] && r_eq && (i < int'(r_bands));
            end else begin
                sec_on[i] = en_pad[i];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= '0;
            r_sec   <= '0;
            r_cbase <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_sec   <= n_sec;
            r_cbase <= n_cbase;
        end
    end

    assign sec_last = r_sec == SW'(SECTIONS - 1);
    assign act      = (r_state == ST_SEC) && sec_on[r_sec];

    always_comb begin
        n_state    = r_state;
        n_ph       = r_ph;
        n_sec      = r_sec;
        n_cbase    = r_cbase;
        knee_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (frame_acc && i_frame.req_type == REQ_FRAME) begin
                    n_state = ST_SEC;
                    n_ph    = '0;
                    n_sec   = '0;
                    n_cbase = '0;
                end
            end
            ST_SEC: begin
                if ((r_ph == 4'd0 && !sec_on[r_sec]) || r_ph == PH_SEC_LAST) begin
                    n_ph = '0;
                    if (sec_last) begin
                        n_state = ST_GAIN;
                    end else begin
                        n_sec   = r_sec + SW'(1);
                        n_cbase = r_cbase + CA_W'(COEFS_PER_SEC);
                    end
                end else begin
                    n_ph = r_ph + 4'd1;
                end
            end
            ST_GAIN: begin
                if (r_ph == PH_GAIN_LAST) begin
                    knee_start = 1'b1;
                    n_state    = ST_KNEE;
                    n_ph       = '0;
                end else begin
                    n_ph = r_ph + 4'd1;
                end
            end
            ST_KNEE: begin
                if (div_busy == 2'b00 && out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- memories ----------------
    assign coef_wfull = (CWA_W'(i_frame.section_index) << 2) + CWA_W'(i_frame.section_index)
                      + CWA_W'(i_frame.coef_index);
    assign coef_waddr = coef_wfull[CA_W-1:0];
    assign coef_we    = frame_acc && i_frame.req_type == REQ_COEF
                      && int'(i_frame.section_index) < SECTIONS
                      && int'(i_frame.coef_index) < COEFS_PER_SEC;
    // b0 b1 b2 a1 a2 fetched on even phases, each held for the left and then the right product
    assign coef_re    = act && !r_ph[0] && r_ph <= 4'd8;
    assign coef_raddr = r_cbase + CA_W'(r_ph >> 1);

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= i_frame.coef_value;
        end
        if (coef_re) begin
            r_coef_q <= coef_mem[coef_raddr];
        end
    end

    // rows are read in phases 0-1 and written back in 11-12, never the same row at once
    assign z_re    = act && (r_ph == 4'd0 || r_ph == 4'd1);
    assign z_raddr = {r_sec, r_ph[0]};
    assign z_we    = (r_state == ST_SEC) && (r_ph == 4'd11 || r_ph == PH_SEC_LAST);
    assign z_waddr = {r_sec, ~r_ph[0]};
    assign z_wdata = {r_s1[ch][DLY_W-1:0],
                      sat_dly((DLY_W+2)'(r_s2[ch]) - (DLY_W+2)'(r_rnd))};

    always_ff @(posedge i_clk) begin
        if (z_we) begin
            dly_mem[z_waddr] <= z_wdata;
        end
        if (z_re) begin
            r_zrow_q <= dly_mem[z_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zval    <= '0;
            r_zrow_ok <= 1'b0;
        end else begin
            if (z_we) begin
                r_zval[z_waddr] <= 1'b1;
            end
            if (z_re) begin
                r_zrow_ok <= r_zval[z_raddr];
            end
        end
    end

    assign z_rd1 = r_zrow_ok ? $signed(r_zrow_q[2*DLY_W-1:DLY_W]) : '0;
    assign z_rd2 = r_zrow_ok ? $signed(r_zrow_q[DLY_W-1:0]) : '0;

    // ---------------- multiplier and rounding ----------------
    // in the sections odd phases work on left, even phases on right; in the gain phases even is left
    assign ch = ~r_ph[0];

    always_comb begin
        if (r_state == ST_GAIN) begin
            mul_a = MUL_W'(r_x[r_ph[0]]);
            mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, r_gain[r_ph[0]]});
        end else begin
            mul_a = (r_ph <= 4'd6) ? MUL_W'(r_x[ch]) : MUL_W'(r_y[ch]);
            mul_b = MUL_W'(r_coef_q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= mul_a * mul_b;
        r_prod_gain <= r_state == ST_GAIN;
        r_rnd       <= r_prod_gain ? rnd_prod(r_prod, GAIN_FRAC) : rnd_prod(r_prod, COEF_SH);
    end

    // ---------------- section datapath ----------------
    // a product issued in a phase passes through r_prod and then the rounded r_rnd before it is used
    always_ff @(posedge i_clk) begin
        if (frame_acc && i_frame.req_type == REQ_FRAME) begin
            r_x[0] <= SIG_W'(i_frame.left_sample);
            r_x[1] <= SIG_W'(i_frame.right_sample);
            r_last <= i_frame.last_of_buffer;
        end
        if (r_state == ST_SEC) begin
            if (r_ph == 4'd1 || r_ph == 4'd2) begin
                r_z1[ch] <= z_rd1;
                r_z2[ch] <= z_rd2;
            end
            if (r_ph == 4'd3 || r_ph == 4'd4) begin
                r_acc[ch] <= (DLY_W+1)'(r_rnd) + (DLY_W+1)'(r_z1[ch]);
            end
            if (r_ph == 4'd4 || r_ph == 4'd5) begin
                r_y[r_ph[0]] <= y_round(r_acc[r_ph[0]]);
            end
            if (r_ph == 4'd5 || r_ph == 4'd6) begin
                r_s1[ch] <= (DLY_W+1)'(r_rnd) + (DLY_W+1)'(r_z2[ch]);
            end
            if (r_ph == 4'd7 || r_ph == 4'd8) begin
                r_s2[ch] <= r_rnd;
            end
            if (r_ph == 4'd9 || r_ph == 4'd10) begin
                r_s1[ch] <= (DLY_W+1)'(sat_dly((DLY_W+2)'(r_s1[ch]) - (DLY_W+2)'(r_rnd)));
            end
            if (r_ph == 4'd11 || r_ph == PH_SEC_LAST) begin
                r_x[ch] <= r_y[ch];
            end
        end
        if (r_state == ST_GAIN && (r_ph == 4'd2 || r_ph == 4'd3)) begin
            r_v[r_ph[0]] <= r_rnd;
        end
    end

    // ---------------- soft knee ----------------
    for (genvar g = 0; g < 2; g++) begin : g_knee
        logic [DLY_W-1:0]          v_abs;
        logic [QW:0]               q_half;
        logic signed [OUT_EXT_W-1:0] k_mag;
        logic signed [OUT_EXT_W-1:0] k_val;

        assign v_abs      = r_v[g][DLY_W-1] ? DLY_W'(-r_v[g]) : DLY_W'(r_v[g]);
        assign mag[g]     = v_abs[MAG_W-1:0];
        assign knee_gt[g] = mag[g] > MAG_W'(KNEE_T);
        assign knee_d[g]  = mag[g] - MAG_W'(KNEE_T);
        assign q_half     = ({1'b0, div_q[g]} + (QW+1)'(1)) >> 1;
        assign k_mag      = OUT_EXT_W'(KNEE_T) + OUT_EXT_W'(q_half);
        assign k_val      = !knee_gt[g] ? OUT_EXT_W'(r_v[g])
                          : (r_v[g][DLY_W-1] ? -k_mag : k_mag);
        assign knee_res[g] = sat_out(k_val);

        sbeq_knee_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (knee_start),
            .i_d     (knee_d[g]),
            .o_busy  (div_busy[g]),
            .o_q     (div_q[g])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l    <= knee_res[0];
            r_out_r    <= knee_res[1];
            r_out_last <= r_last;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.left_out  = r_out_l;
    assign o_result.right_out = r_out_r;
    assign o_result.last_out  = r_out_last;

    // ---------------- checks ----------------
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten while pending");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEC) |-> (r_sec <= SW'(SECTIONS - 1)))
        else $error("section counter out of range");

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        knee_start |=> (div_busy == 2'b11))
        else $error("knee dividers did not start");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (div_busy == 2'b00))
        else $error("divider busy while sequencer idle");

    a_row_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (z_re && z_we) |-> (z_raddr != z_waddr))
        else $error("delay row read and written in the same cycle");

endmodule

/* rtl/core/sbeq_knee_div.sv */
// restoring divider for the soft knee: q = floor(d * 2^(F+1) / (2^F + 9d))
// one quotient bit per cycle; depends on sbeq_pkg
`timescale 1ns / 1ps

module sbeq_knee_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sbeq_pkg::MAG_W-1:0]   i_d,
    output logic                         o_busy,
    output logic [sbeq_pkg::QW-1:0]      o_q
);
    import sbeq_pkg::*;

    localparam int CNT_W = $clog2(QW + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   trial;
    logic             take;

    assign trial = {r_rem, 1'b0};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    // 2d < den, so the top part of d * 2^(F+1) is the starting remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'({i_d, 1'b0});
            r_den <= (DEN_W'(i_d) << 3) + DEN_W'(i_d) + (DEN_W'(1) << SIG_FRAC);
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= take ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_q   <= {r_q[QW-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

endmodule

/* test/sbeq_checker.sv */
// checker for the stereo biquad eq core: watches the request, result and register channels,
// predicts every processed frame and compares it with what comes out
// depends on sbeq_pkg and sbeq_ifs
`timescale 1ns / 1ps

module sbeq_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sbeq_req_if   frame_ch,
    sbeq_res_if   result_ch,
    sbeq_cfg_if   cfg_ch,
    output int    o_fail_count,
    output int    o_pending
);
    import sbeq_pkg::*;

    localparam int NUM_SEC = PEAK_BANDS_DEF + 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          last;
    } t_frame_out;

    t_frame_out expected_frames[$];

    logic                   eq_on;
    logic [BAND_CNT_W-1:0]  band_cnt;
    logic [SEC_EN_W-1:0]    sec_en;
    logic [GAIN_W-1:0]      gain_l;
    logic [GAIN_W-1:0]      gain_r;
    longint                 coefs[NUM_SEC][COEFS_PER_SEC];
    longint                 z_state[NUM_SEC][2][2];

    initial o_fail_count = 0;

    // a*b / 2^sh, half away from zero, magnitude clipped to 2^47-1
    function automatic longint prod_round(longint a, longint b, int sh);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 128'(-a) : 128'(a);
        ub  = (b < 0) ? 128'(-b) : 128'(b);
        p   = (ua * ub + (128'(1) << (sh - 1))) >> sh;
        if (p > 128'(PROD_LIM)) begin
            p = 128'(PROD_LIM);
        end
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    function automatic longint round_shift(longint v, int k);
        longint u;
        u = (v < 0) ? -v : v;
        u = (u + (longint'(1) << (k - 1))) >>> k;
        return (v < 0) ? -u : u;
    endfunction

    // soft knee d/(1+9d) above the threshold, mirrored below
    function automatic longint knee_limit(longint v);
        longint       t;
        longint       mag;
        logic [127:0] d;
        logic [127:0] den;
        logic [127:0] q;
        t   = KNEE_T_I;
        mag = (v < 0) ? -v : v;
        if (mag <= t) begin
            return v;
        end
        d   = 128'(mag - t);
        den = (128'(1) << SIG_FRAC) + 128'(9) * d;
        q   = (((d << (SIG_FRAC + 1)) / den) + 1) >> 1;
        return (v < 0) ? -(t + longint'(q[63:0])) : t + longint'(q[63:0]);
    endfunction

    function automatic longint run_biquad(int s, int ch, longint x);
        longint y;
        longint acc;
        acc = prod_round(x, coefs[s][0], COEF_SH) + z_state[s][ch][0];
        y   = clip(round_shift(acc, Y_SH), SIG_W);
        z_state[s][ch][0] = clip(prod_round(x, coefs[s][1], COEF_SH)
                                 - prod_round(y, coefs[s][3], COEF_SH)
                                 + z_state[s][ch][1], DLY_W);
        z_state[s][ch][1] = clip(prod_round(x, coefs[s][2], COEF_SH)
                                 - prod_round(y, coefs[s][4], COEF_SH), DLY_W);
        return y;
    endfunction

    function automatic t_frame_out frame_response(logic signed [SAMPLE_BITS-1:0] l,
                                                  logic signed [SAMPLE_BITS-1:0] r,
                                                  logic last);
        longint     sig[2];
        longint     v;
        int         bands;
        logic       on;
        t_frame_out o;
        sig[0] = l;
        sig[1] = r;
        bands  = (band_cnt > PEAK_BANDS_DEF) ? PEAK_BANDS_DEF : int'(band_cnt);
        for (int s = 0; s < NUM_SEC; s++) begin
            on = sec_en[s];
            if (s < PEAK_BANDS_DEF) begin
                on = on && eq_on && (s < bands);
            end
            if (on) begin
                for (int ch = 0; ch < 2; ch++) begin
                    sig[ch] = run_biquad(s, ch, sig[ch]);
                end
            end
        end
        v = clip(knee_limit(prod_round(sig[0], longint'(gain_l), GAIN_FRAC)), SAMPLE_BITS);
        o.left = v[SAMPLE_BITS-1:0];
        v = clip(knee_limit(prod_round(sig[1], longint'(gain_r), GAIN_FRAC)), SAMPLE_BITS);
        o.right = v[SAMPLE_BITS-1:0];
        o.last  = last;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_frame_out got;
        t_frame_out want;
        if (!i_rst_n) begin
            eq_on    = 1'b0;
            band_cnt = '0;
            sec_en   = '0;
            gain_l   = GAIN_UNITY;
            gain_r   = GAIN_UNITY;
            z_state  = '{default: '{default: '{default: 0}}};
            coefs    = '{default: '{default: 0}};
            expected_frames.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = '{result_ch.left_out, result_ch.right_out, result_ch.last_out};
                if (expected_frames.size() == 0) begin
                    $error("unexpected result transaction: left %0d right %0d last %0d",
                           got.left, got.right, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, got.left);
                        o_fail_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, got.right);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_out: expected %0d, got %0d", want.last, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_EQ_ENABLE:  eq_on    = cfg_ch.data[0];
                    CFG_BAND_COUNT: band_cnt = cfg_ch.data[BAND_CNT_W-1:0];
                    CFG_SEC_ENABLE: sec_en   = cfg_ch.data[SEC_EN_W-1:0];
                    CFG_GAIN_LEFT:  gain_l   = cfg_ch.data[GAIN_W-1:0];
                    CFG_GAIN_RIGHT: gain_r   = cfg_ch.data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (frame_ch.valid && frame_ch.ready) begin
                if (frame_ch.req_type == REQ_COEF) begin
                    // writes to a missing section or coefficient are dropped
                    if (frame_ch.section_index < NUM_SEC
                        && frame_ch.coef_index < COEFS_PER_SEC) begin
                        coefs[frame_ch.section_index][frame_ch.coef_index] =
                            longint'(frame_ch.coef_value);
                    end
                end else begin
                    expected_frames.push_back(frame_response(frame_ch.left_sample,
                                                             frame_ch.right_sample,
                                                             frame_ch.last_of_buffer));
                end
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

/* test/testbench.sv */
// testbench top for the stereo biquad eq core: clock, reset, stimulus and verdict
// depends on sbeq_pkg, sbeq_ifs, the core and sbeq_checker
`timescale 1ns / 1ps

module testbench;
    import sbeq_pkg::*;

    localparam int NUM_SEC     = PEAK_BANDS_DEF + 2;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;

    sbeq_req_if frame_ch ();
    sbeq_res_if result_ch ();
    sbeq_cfg_if cfg_ch ();

    always #6 i_clk = ~i_clk;

    stereo_biquad_eq_soft_limiter_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    sbeq_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .frame_ch     (frame_ch),
        .result_ch    (result_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return OUT_MAX;
            1: return OUT_MIN;
            2: return SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // keeps each section stable: |a1| <= 0.625, |a2| <= 0.3125
    function automatic logic [COEF_W-1:0] tame_coef(int ci);
        int m;
        case (ci)
            0: return COEF_W'($urandom_range(1 << 26, 3 << 27));
            3: m = 5 << 25;
            4: m = 5 << 24;
            default: m = 1 << 28;
        endcase
        return COEF_W'(int'($urandom_range(0, 2 * m)) - m);
    endfunction

    always @(posedge i_clk) begin
        if (calm) begin
            result_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(logic kind, logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                             logic last, logic [SEC_IDX_W-1:0] sec,
                             logic [COEF_IDX_W-1:0] ci, logic [COEF_W-1:0] val);
        int g;
        g = gap_len();
        if (g > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.req_type       <= kind;
        frame_ch.left_sample    <= l;
        frame_ch.right_sample   <= r;
        frame_ch.last_of_buffer <= last;
        frame_ch.section_index  <= sec;
        frame_ch.coef_index     <= ci;
        frame_ch.coef_value     <= val;
        do @(posedge i_clk); while (!frame_ch.ready);
    endtask

    task automatic send_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                              logic last);
        send_item(REQ_FRAME, l, r, last, SEC_IDX_W'($urandom), COEF_IDX_W'($urandom),
                  COEF_W'($urandom));
    endtask

    task automatic send_coef(int sec, int ci, logic [COEF_W-1:0] val);
        send_item(REQ_COEF, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom),
                  SEC_IDX_W'(sec), COEF_IDX_W'(ci), val);
    endtask

    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // valid is dropped after each write so back-to-back writes never collide
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1 << 19, 3 << 20));
        endcase
    endfunction

    task automatic random_settings();
        cfg_write(CFG_EQ_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
        cfg_write(CFG_BAND_COUNT, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                                               : CFG_DATA_W'(PEAK_BANDS_DEF));
        cfg_write(CFG_SEC_ENABLE, ($urandom_range(0, 4) == 0) ? CFG_DATA_W'(12'hfff)
                                                               : CFG_DATA_W'($urandom));
        cfg_write(CFG_GAIN_LEFT, pick_gain());
        cfg_write(CFG_GAIN_RIGHT, pick_gain());
    endtask

    initial begin
        frame_ch.valid          = 1'b0;
        frame_ch.req_type       = REQ_FRAME;
        frame_ch.left_sample    = '0;
        frame_ch.right_sample   = '0;
        frame_ch.last_of_buffer = 1'b0;
        frame_ch.section_index  = '0;
        frame_ch.coef_index     = '0;
        frame_ch.coef_value     = '0;
        result_ch.ready         = 1'b1;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every coefficient gets a value before any section can run
        for (int s = 0; s < NUM_SEC; s++) begin
            for (int c = 0; c < COEFS_PER_SEC; c++) send_coef(s, c, tame_coef(c));
        end

        // reset settings: all sections bypassed, unity gain
        send_frame(OUT_MAX, OUT_MIN, 1'b1);
        send_frame(OUT_MIN, OUT_MAX, 1'b0);
        send_frame('0, '0, 1'b1);
        send_frame('1, 24'd1, 1'b0);
        // writes to a missing section or coefficient index are dropped
        send_coef(15, 0, COEF_W'($urandom));
        send_coef(0, 7, COEF_W'($urandom));
        wait_idle();

        // everything on, band count beyond the band total, extreme gains
        cfg_write(CFG_EQ_ENABLE, CFG_DATA_W'(1));
        cfg_write(CFG_BAND_COUNT, CFG_DATA_W'(15));
        cfg_write(CFG_SEC_ENABLE, CFG_DATA_W'(12'hfff));
        cfg_write(CFG_GAIN_LEFT, '1);
        cfg_write(CFG_GAIN_RIGHT, '0);
        send_frame(OUT_MAX, OUT_MAX, 1'b0);
        send_frame(OUT_MIN, OUT_MIN, 1'b1);
        send_frame(24'd7_800_000, -24'sd7_800_000, 1'b0);
        send_frame(24'd100, -24'sd100, 1'b1);
        wait_idle();

        // shelves and peak bands 0 and 2 only, knee on both sides
        cfg_write(CFG_BAND_COUNT, CFG_DATA_W'(3));
        cfg_write(CFG_SEC_ENABLE, CFG_DATA_W'(12'hc05));
        cfg_write(CFG_GAIN_LEFT, GAIN_W'(2) << GAIN_FRAC);
        cfg_write(CFG_GAIN_RIGHT, GAIN_W'(3) << GAIN_FRAC);
        send_frame(24'd3_900_000, -24'sd3_900_000, 1'b0);
        send_frame(-24'sd4_000_000, 24'd4_100_000, 1'b1);
        send_frame(OUT_MAX, OUT_MIN, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            calm = (phase % 3 == 2);
            random_settings();
            for (int n = 0; n < 72; n++) begin
                if (n == 40 && phase % 2 == 1) wait_idle();
                if ($urandom_range(0, 99) < 85) begin
                    send_frame(pick_sample(), pick_sample(), 1'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1)) send_coef($urandom_range(12, 15),
                                                        $urandom_range(0, 7), $urandom);
                    else send_coef($urandom_range(0, 15), $urandom_range(5, 7), $urandom);
                end else begin
                    int ci;
                    ci = $urandom_range(0, 4);
                    send_coef($urandom_range(0, NUM_SEC - 1), ci,
                              ($urandom_range(0, 8) == 0) ? COEF_W'($urandom) : tame_coef(ci));
                end
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
